// ----- hw/rtl/rvs_pkg.sv -----
`timescale 1ns / 1ps

package rvs_pkg;

    // field widths
    localparam int COORD_BITS    = 13;
    localparam int COLOR_BITS    = 16;
    localparam int DIM_BITS      = 14;
    localparam int STR_BITS      = 16;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;

    // stream payload widths, padded to whole bytes
    localparam int IN_RAW_BITS  = 2 * COORD_BITS + 3 * COLOR_BITS;
    localparam int IN_TDATA_W   = ((IN_RAW_BITS + 7) / 8) * 8;
    localparam int OUT_RAW_BITS = 3 * COLOR_BITS;
    localparam int OUT_TDATA_W  = ((OUT_RAW_BITS + 7) / 8) * 8;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_WIDTH       = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_HEIGHT      = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_VIGNETTE_STRENGTH = 2'd2;

    // register reset values
    localparam logic [DIM_BITS-1:0] WIDTH_RESET    = 14'd1024;
    localparam logic [DIM_BITS-1:0] HEIGHT_RESET   = 14'd768;
    localparam logic [STR_BITS-1:0] STRENGTH_RESET = 16'd16384;
    localparam logic [STR_BITS-1:0] STRENGTH_MAX   = 16'd32768;

    // distance datapath
    localparam int DIFF_BITS = (COORD_BITS + 1 > DIM_BITS) ? COORD_BITS + 1 : DIM_BITS;
    localparam int SQ_BITS   = 2 * DIFF_BITS;
    localparam int SUM_W     = SQ_BITS + 2;
    localparam int SUM_BITS  = 29;
    localparam int ROOT_BITS = 32;
    localparam int RAD_W     = 2 * ROOT_BITS;
    localparam int RAD_SHIFT = 34;
    localparam int RAD_PAD   = RAD_W - SUM_BITS - RAD_SHIFT;
    localparam int REM_W     = ROOT_BITS + 4;
    localparam int QUO_BITS  = 18;
    localparam int D_BITS    = QUO_BITS - 1;

    // q.16 shading values (one is 65536, so 17 bits)
    localparam int Q_BITS = 17;
    localparam logic [Q_BITS-1:0] Q16_ONE  = 17'd65536;
    localparam logic [Q_BITS-1:0] EDGE_LOW = 17'd26214;
    localparam logic [D_BITS-1:0] D_MAX    = 17'd131071;
    localparam logic [Q_BITS:0]   U_BASE   = 18'd196608;
    localparam int ROUND16 = 32768;
    localparam int ROUND15 = 16384;

    typedef struct packed {
        logic [COLOR_BITS-1:0] blue;
        logic [COLOR_BITS-1:0] green;
        logic [COLOR_BITS-1:0] red;
    } color_t;

    typedef struct packed {
        logic                 far;
        logic [ROOT_BITS-1:0] root;
        color_t               color;
    } root_item_t;

    typedef struct packed {
        logic              far;
        logic [D_BITS-1:0] distance;
        color_t            color;
    } dist_item_t;

endpackage

// ----- hw/rtl/rvs_radius.sv -----
`timescale 1ns / 1ps

module rvs_radius (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              en,
    input  logic [rvs_pkg::DIM_BITS-1:0]      width_eff,
    input  logic [rvs_pkg::DIM_BITS-1:0]      height_eff,
    input  logic                              in_valid,
    input  logic [rvs_pkg::COORD_BITS-1:0]    row,
    input  logic [rvs_pkg::COORD_BITS-1:0]    column,
    input  rvs_pkg::color_t                   color_in,
    output logic                              out_valid,
    output rvs_pkg::root_item_t               out_item
);
    import rvs_pkg::*;

    localparam int NSTG = ROOT_BITS;

    // offset from centre
    logic                 dv_reg;
    logic [DIFF_BITS-1:0] dx_reg, dy_reg;
    color_t               dc_reg;
    logic [DIFF_BITS:0]   col2, row2, wext, hext;
    logic [DIFF_BITS-1:0] dx_next, dy_next;

    // squares
    logic                 qv_reg;
    logic [SQ_BITS-1:0]   sqx_reg, sqy_reg;
    color_t               qc_reg;

    // sum and root stages, index 0 holds the sum
    logic [SUM_W-1:0]     sum_full;
    logic                 sv_reg   [0:NSTG];
    logic [SUM_BITS-1:0]  sum_reg  [0:NSTG];
    logic                 far_reg  [0:NSTG];
    color_t               col_reg  [0:NSTG];
    logic [ROOT_BITS-1:0] root_reg [0:NSTG];
    logic [REM_W-1:0]     rem_reg  [0:NSTG];
    logic [ROOT_BITS-1:0] root_next [0:NSTG-1];
    logic [REM_W-1:0]     rem_next  [0:NSTG-1];

    assign col2 = (DIFF_BITS + 1)'({column, 1'b0});
    assign row2 = (DIFF_BITS + 1)'({row, 1'b0});
    assign wext = (DIFF_BITS + 1)'(width_eff);
    assign hext = (DIFF_BITS + 1)'(height_eff);
    assign dx_next = (col2 >= wext) ? DIFF_BITS'(col2 - wext) : DIFF_BITS'(wext - col2);
    assign dy_next = (row2 >= hext) ? DIFF_BITS'(row2 - hext) : DIFF_BITS'(hext - row2);
    assign sum_full = SUM_W'(sqx_reg) + SUM_W'(sqy_reg);

    // one root bit per stage: restoring square root of sum << 34
    always_comb begin
        logic [RAD_W-1:0] rad;
        logic [REM_W-1:0] rem_sh;
        logic [REM_W-1:0] trial;
        int               p;
        for (int i = 0; i < NSTG; i++) begin
            p         = NSTG - 1 - i;
            rad       = {{RAD_PAD{1'b0}}, sum_reg[i], {RAD_SHIFT{1'b0}}};
            rem_sh    = {rem_reg[i][REM_W-3:0], rad[2*p+1 -: 2]};
            trial     = REM_W'({root_reg[i], 2'b01});
            if (rem_sh >= trial) begin
                rem_next[i]  = rem_sh - trial;
                root_next[i] = {root_reg[i][ROOT_BITS-2:0], 1'b1};
            end else begin
                rem_next[i]  = rem_sh;
                root_next[i] = {root_reg[i][ROOT_BITS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_reg <= 1'b0;
            qv_reg <= 1'b0;
            for (int i = 0; i <= NSTG; i++) begin
                sv_reg[i] <= 1'b0;
            end
        end else if (en) begin
            dv_reg    <= in_valid;
            qv_reg    <= dv_reg;
            sv_reg[0] <= qv_reg;
            for (int i = 0; i < NSTG; i++) begin
                sv_reg[i+1] <= sv_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dx_reg      <= dx_next;
            dy_reg      <= dy_next;
            dc_reg      <= color_in;
            sqx_reg     <= SQ_BITS'(dx_reg) * SQ_BITS'(dx_reg);
            sqy_reg     <= SQ_BITS'(dy_reg) * SQ_BITS'(dy_reg);
            qc_reg      <= dc_reg;
            sum_reg[0]  <= sum_full[SUM_BITS-1:0];
            far_reg[0]  <= |sum_full[SUM_W-1:SUM_BITS];
            col_reg[0]  <= qc_reg;
            root_reg[0] <= '0;
            rem_reg[0]  <= '0;
            for (int i = 0; i < NSTG; i++) begin
                sum_reg[i+1]  <= sum_reg[i];
                far_reg[i+1]  <= far_reg[i];
                col_reg[i+1]  <= col_reg[i];
                root_reg[i+1] <= root_next[i];
                rem_reg[i+1]  <= rem_next[i];
            end
        end
    end

    assign out_valid      = sv_reg[NSTG];
    assign out_item.far   = far_reg[NSTG];
    assign out_item.root  = root_reg[NSTG];
    assign out_item.color = col_reg[NSTG];

endmodule

// ----- hw/rtl/rvs_scale.sv -----
`timescale 1ns / 1ps

module rvs_scale (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  logic [rvs_pkg::DIM_BITS-1:0] height_eff,
    input  logic                         in_valid,
    input  rvs_pkg::root_item_t          in_item,
    output logic                         out_valid,
    output rvs_pkg::dist_item_t          out_item
);
    import rvs_pkg::*;

    localparam int NSTG = QUO_BITS;

    // index 0 holds the range check and the leading remainder
    logic                 v_reg    [0:NSTG];
    logic [ROOT_BITS-1:0] root_reg [0:NSTG];
    logic                 far_reg  [0:NSTG];
    logic                 sat_reg  [0:NSTG];
    color_t               col_reg  [0:NSTG];
    logic [DIM_BITS-1:0]  rem_reg  [0:NSTG];
    logic [QUO_BITS-1:0]  quo_reg  [0:NSTG];
    logic [DIM_BITS-1:0]  rem_next [0:NSTG-1];
    logic [QUO_BITS-1:0]  quo_next [0:NSTG-1];

    logic                 sat_next;
    logic [QUO_BITS:0]    quo_inc;
    logic [QUO_BITS-1:0]  quo_half;
    logic [D_BITS-1:0]    dist_next;

    // quotient past 2^18 means the distance saturates
    assign sat_next = in_item.root >= (ROOT_BITS'(height_eff) << QUO_BITS);

    always_comb begin
        logic [DIM_BITS:0] rem_sh;
        logic [DIM_BITS:0] hh;
        int                b;
        hh = {1'b0, height_eff};
        for (int i = 0; i < NSTG; i++) begin
            b      = NSTG - 1 - i;
            rem_sh = {rem_reg[i], root_reg[i][b]};
            if (rem_sh >= hh) begin
                rem_next[i] = DIM_BITS'(rem_sh - hh);
                quo_next[i] = {quo_reg[i][QUO_BITS-2:0], 1'b1};
            end else begin
                rem_next[i] = rem_sh[DIM_BITS-1:0];
                quo_next[i] = {quo_reg[i][QUO_BITS-2:0], 1'b0};
            end
        end
    end

    // largest c with (2c-1) <= root/h
    assign quo_inc   = (QUO_BITS + 1)'(quo_reg[NSTG]) + (QUO_BITS + 1)'(1);
    assign quo_half  = quo_inc[QUO_BITS:1];
    assign dist_next = (sat_reg[NSTG] || quo_half[QUO_BITS-1]) ? D_MAX
                                                                : quo_half[D_BITS-1:0];

    logic   ov_reg;
    logic   ofar_reg;
    logic [D_BITS-1:0] odist_reg;
    color_t ocol_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ov_reg <= 1'b0;
            for (int i = 0; i <= NSTG; i++) begin
                v_reg[i] <= 1'b0;
            end
        end else if (en) begin
            v_reg[0] <= in_valid;
            for (int i = 0; i < NSTG; i++) begin
                v_reg[i+1] <= v_reg[i];
            end
            ov_reg <= v_reg[NSTG];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            root_reg[0] <= in_item.root;
            far_reg[0]  <= in_item.far;
            sat_reg[0]  <= sat_next;
            col_reg[0]  <= in_item.color;
            rem_reg[0]  <= in_item.root[ROOT_BITS-1:QUO_BITS];
            quo_reg[0]  <= '0;
            for (int i = 0; i < NSTG; i++) begin
                root_reg[i+1] <= root_reg[i];
                far_reg[i+1]  <= far_reg[i];
                sat_reg[i+1]  <= sat_reg[i];
                col_reg[i+1]  <= col_reg[i];
                rem_reg[i+1]  <= rem_next[i];
                quo_reg[i+1]  <= quo_next[i];
            end
            ofar_reg  <= far_reg[NSTG];
            odist_reg <= dist_next;
            ocol_reg  <= col_reg[NSTG];
        end
    end

    assign out_valid         = ov_reg;
    assign out_item.far      = ofar_reg;
    assign out_item.distance = odist_reg;
    assign out_item.color    = ocol_reg;

endmodule

// ----- hw/rtl/rvs_shade.sv -----
`timescale 1ns / 1ps

module rvs_shade (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  logic [rvs_pkg::STR_BITS-1:0] strength,
    input  logic                         in_valid,
    input  rvs_pkg::dist_item_t          in_item,
    output logic                         out_valid,
    output rvs_pkg::color_t              out_color
);
    import rvs_pkg::*;

    localparam int NSTG  = 8;
    localparam int NCOL  = 6;
    localparam int TT_W  = 2 * Q_BITS;
    localparam int P_W   = 2 * Q_BITS + 1;
    localparam int KS_W  = Q_BITS + STR_BITS;
    localparam int PR_W  = COLOR_BITS + Q_BITS;

    logic   v_reg   [1:NSTG];
    color_t col_reg [1:NCOL];

    logic [Q_BITS-1:0]  t_reg, t_next, t_diff;
    logic [TT_W-1:0]    tt_reg;
    logic [Q_BITS:0]    u_reg, u_next;
    logic [TT_W-1:0]    tt_round;
    logic [Q_BITS-1:0]  t2;
    logic [P_W-1:0]     p_reg, p_round;
    logic [Q_BITS-1:0]  s_reg, s_next;
    logic [Q_BITS+1:0]  s_wide;
    logic [KS_W-1:0]    ks_reg, ks_round;
    logic [Q_BITS:0]    k_wide;
    logic [Q_BITS-1:0]  k_val;
    logic [Q_BITS-1:0]  f_reg;
    logic [PR_W-1:0]    pr_red_reg, pr_green_reg, pr_blue_reg;
    logic [PR_W-1:0]    rd_red, rd_green, rd_blue;
    color_t             out_reg, out_next;

    // ramp position: clamp(d - 0.4, 0, 1), far pixels sit at 1
    assign t_diff = in_item.distance - EDGE_LOW;
    always_comb begin
        if (in_item.far) begin
            t_next = Q16_ONE;
        end else if (in_item.distance > EDGE_LOW) begin
            t_next = (t_diff > Q16_ONE) ? Q16_ONE : t_diff;
        end else begin
            t_next = '0;
        end
    end

    assign u_next   = U_BASE - {t_reg, 1'b0};
    assign tt_round = tt_reg + TT_W'(ROUND16);
    assign t2       = tt_round[Q_BITS+15:16];

    // smoothstep, capped at one
    assign p_round = p_reg + P_W'(ROUND16);
    assign s_wide  = p_round[P_W-1:16];
    assign s_next  = (s_wide > (Q_BITS + 2)'(Q16_ONE)) ? Q16_ONE : s_wide[Q_BITS-1:0];

    // darkening in q.16 and the factor left over
    assign ks_round = ks_reg + KS_W'(ROUND15);
    assign k_wide   = ks_round[KS_W-1:15];
    assign k_val    = (k_wide > (Q_BITS + 1)'(Q16_ONE)) ? Q16_ONE : k_wide[Q_BITS-1:0];

    assign rd_red   = pr_red_reg + PR_W'(ROUND16);
    assign rd_green = pr_green_reg + PR_W'(ROUND16);
    assign rd_blue  = pr_blue_reg + PR_W'(ROUND16);
    assign out_next.red   = rd_red[COLOR_BITS+15:16];
    assign out_next.green = rd_green[COLOR_BITS+15:16];
    assign out_next.blue  = rd_blue[COLOR_BITS+15:16];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 1; i <= NSTG; i++) begin
                v_reg[i] <= 1'b0;
            end
        end else if (en) begin
            v_reg[1] <= in_valid;
            for (int i = 1; i < NSTG; i++) begin
                v_reg[i+1] <= v_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            col_reg[1] <= in_item.color;
            for (int i = 1; i < NCOL; i++) begin
                col_reg[i+1] <= col_reg[i];
            end
            t_reg        <= t_next;
            tt_reg       <= TT_W'(t_reg) * TT_W'(t_reg);
            u_reg        <= u_next;
            p_reg        <= P_W'(t2) * P_W'(u_reg);
            s_reg        <= s_next;
            ks_reg       <= KS_W'(s_reg) * KS_W'(strength);
            f_reg        <= Q16_ONE - k_val;
            pr_red_reg   <= PR_W'(col_reg[NCOL].red) * PR_W'(f_reg);
            pr_green_reg <= PR_W'(col_reg[NCOL].green) * PR_W'(f_reg);
            pr_blue_reg  <= PR_W'(col_reg[NCOL].blue) * PR_W'(f_reg);
            out_reg      <= out_next;
        end
    end

    assign out_valid = v_reg[NSTG];
    assign out_color = out_reg;

endmodule

// ----- hw/rtl/rvs_skid.sv -----
`timescale 1ns / 1ps

module rvs_skid (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    input  rvs_pkg::color_t in_item,
    output logic            en,
    output logic            m_valid,
    input  logic            m_ready,
    output rvs_pkg::color_t m_item
);
    import rvs_pkg::*;

    localparam logic [1:0] FILL_NONE = 2'd0;
    localparam logic [1:0] FILL_ONE  = 2'd1;
    localparam logic [1:0] FILL_TWO  = 2'd2;

    logic [1:0] count_reg, count_next;
    color_t     head_reg, head_next;
    color_t     spare_reg, spare_next;
    logic       push, pop;

    // pipeline moves only while a slot is free
    assign en      = (count_reg != FILL_TWO);
    assign m_valid = (count_reg != FILL_NONE);
    assign push    = en && in_valid;
    assign pop     = m_valid && m_ready;

    always_comb begin
        count_next = count_reg;
        head_next  = head_reg;
        spare_next = spare_reg;
        case (count_reg)
            FILL_NONE: begin
                if (push) begin
                    head_next  = in_item;
                    count_next = FILL_ONE;
                end
            end
            FILL_ONE: begin
                if (push && pop) begin
                    head_next = in_item;
                end else if (push) begin
                    spare_next = in_item;
                    count_next = FILL_TWO;
                end else if (pop) begin
                    count_next = FILL_NONE;
                end
            end
            FILL_TWO: begin
                if (pop) begin
                    head_next  = spare_reg;
                    count_next = FILL_ONE;
                end
            end
            default: begin
                count_next = FILL_NONE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= FILL_NONE;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        head_reg  <= head_next;
        spare_reg <= spare_next;
    end

    assign m_item = head_reg;

endmodule

// ----- hw/rtl/radial_vignette_shading.sv -----
`timescale 1ns / 1ps

// channel   dir  handshake            payload
// s_        in   s_tvalid / s_tready  s_tdata: pixel_row, pixel_column, red_in, green_in, blue_in
// m_        out  m_tvalid / m_tready  m_tdata: red_out, green_out, blue_out
// cfg_      in   cfg_valid/cfg_ready  cfg_index, cfg_data (0 width, 1 height, 2 strength)
//
// one item per clock sustained while the output buffer has a free entry
// the pipeline holds a 32-stage square root and an 18-stage divider by height
// reset is synchronous: clears all valid bits, registers return to 1024 / 768 / 0.5
// a two-entry output buffer decouples m_tready; the pipeline freezes only when
// both entries hold results, so new items are taken while one result waits
// cfg_ready is always high; registers are read live by the stages that use them

module radial_vignette_shading (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [12:0] pixel_row, [25:13] pixel_column, [41:26] red_in,
    // [57:42] green_in, [73:58] blue_in, rest zero
    input  logic [rvs_pkg::IN_TDATA_W-1:0]    s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [15:0] red_out, [31:16] green_out, [47:32] blue_out
    output logic [rvs_pkg::OUT_TDATA_W-1:0]   m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rvs_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [rvs_pkg::CFG_DATA_BITS-1:0] cfg_data
);
    import rvs_pkg::*;

    logic [DIM_BITS-1:0] image_width_reg;
    logic [DIM_BITS-1:0] image_height_reg;
    logic [STR_BITS-1:0] strength_reg;

    logic [DIM_BITS-1:0] height_eff;
    logic [STR_BITS-1:0] strength_eff;

    logic [COORD_BITS-1:0] pixel_row, pixel_column;
    color_t                color_in;

    logic       en;
    logic       root_valid, dist_valid, shade_valid;
    root_item_t root_item;
    dist_item_t dist_item;
    color_t     shade_color, out_color;

    // ---------------------------------------------------------------
    // configuration registers, writes outside the list are dropped
    // ---------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg  <= WIDTH_RESET;
            image_height_reg <= HEIGHT_RESET;
            strength_reg     <= STRENGTH_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_IMAGE_WIDTH:       image_width_reg  <= cfg_data[DIM_BITS-1:0];
                CFG_IMAGE_HEIGHT:      image_height_reg <= cfg_data[DIM_BITS-1:0];
                CFG_VIGNETTE_STRENGTH: strength_reg     <= cfg_data[STR_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // zero height acts as one; strength saturates at full
    assign height_eff   = (image_height_reg == '0) ? DIM_BITS'(1) : image_height_reg;
    assign strength_eff = (strength_reg > STRENGTH_MAX) ? STRENGTH_MAX : strength_reg;

    // ---------------------------------------------------------------
    // input unpacking
    // ---------------------------------------------------------------
    assign pixel_row      = s_tdata[COORD_BITS-1:0];
    assign pixel_column   = s_tdata[2*COORD_BITS-1:COORD_BITS];
    assign color_in.red   = s_tdata[2*COORD_BITS +: COLOR_BITS];
    assign color_in.green = s_tdata[2*COORD_BITS+COLOR_BITS +: COLOR_BITS];
    assign color_in.blue  = s_tdata[2*COORD_BITS+2*COLOR_BITS +: COLOR_BITS];

    // whole pipeline advances together, held only by a full output buffer
    assign s_tready = en;

    // squared offset from centre, then integer root of offset^2 << 34
    rvs_radius u_radius (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .width_eff  (image_width_reg),
        .height_eff (height_eff),
        .in_valid   (s_tvalid),
        .row        (pixel_row),
        .column     (pixel_column),
        .color_in   (color_in),
        .out_valid  (root_valid),
        .out_item   (root_item)
    );

    // root / height gives the rounded q.16 distance
    rvs_scale u_scale (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .height_eff (height_eff),
        .in_valid   (root_valid),
        .in_item    (root_item),
        .out_valid  (dist_valid),
        .out_item   (dist_item)
    );

    // smoothstep ramp, factor and per-channel scaling
    rvs_shade u_shade (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .strength  (strength_eff),
        .in_valid  (dist_valid),
        .in_item   (dist_item),
        .out_valid (shade_valid),
        .out_color (shade_color)
    );

    // output buffer
    rvs_skid u_skid (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (shade_valid),
        .in_item  (shade_color),
        .en       (en),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_item   (out_color)
    );

    assign m_tdata = OUT_TDATA_W'({out_color.blue, out_color.green, out_color.red});

endmodule

// ----- bench/radial_vignette_shading_tb.sv -----
`timescale 1ns / 1ps

module radial_vignette_shading_tb;

    import rvs_pkg::*;

    // watchdog: cycles in a row with no handshake on any channel
    localparam int STALL_LIMIT = 4000;
    // accept-to-result latency of the block, plus margin for the final pause
    localparam int TAIL_CYCLES = 100;
    // writes here must leave every register untouched
    localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED_INDEX = 2'd3;

    // q.16 constants of the shading curve
    localparam longint unsigned ONE_Q16   = 65536;
    localparam longint unsigned RAMP_EDGE = 26214;
    localparam longint unsigned FAR_SUM   = 64'd1 << 29;

    typedef struct packed {
        logic [COORD_BITS-1:0] row;
        logic [COORD_BITS-1:0] col;
        color_t                color;
    } pixel_t;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [IN_TDATA_W-1:0]    s_tdata = '0;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]   m_tdata;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;

    // shadow copy of the block's registers
    logic [DIM_BITS-1:0] img_width  = WIDTH_RESET;
    logic [DIM_BITS-1:0] img_height = HEIGHT_RESET;
    logic [STR_BITS-1:0] strength   = STRENGTH_RESET;

    // shaded colors still owed by the block, oldest first
    color_t shaded_due[$];

    // idle chances in percent, changed between traffic phases
    int send_idle_pct = 15;
    int recv_idle_pct = 53;

    int errors = 0;
    int pixels_sent = 0;
    int pixels_checked = 0;
    int regs_written = 0;
    int stall_cycles = 0;

    color_t result_seen;
    color_t result_owed;

    radial_vignette_shading dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // one printed line per mismatch
    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        errors++;
    endtask

    // shading of one pixel under the current shadow registers
    function automatic color_t shade_pixel(input pixel_t px);
        longint          dx;
        longint          dy;
        longint unsigned h;
        longint unsigned st;
        longint unsigned sum;
        longint unsigned distance;
        longint unsigned trial;
        longint unsigned ramp;
        longint unsigned ramp_sq;
        longint unsigned taper;
        longint unsigned smooth;
        longint unsigned dark;
        longint unsigned gain;
        logic [127:0]    span;
        logic [127:0]    bound;
        color_t          shaded;
        // a zero height would divide by zero, so it counts as one
        h  = (img_height == 0) ? 1 : img_height;
        st = (strength > STRENGTH_MAX) ? STRENGTH_MAX : strength;
        dx = 2 * longint'(px.col) - longint'(img_width);
        dy = 2 * longint'(px.row) - longint'(h);
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        sum = longint'(dx * dx + dy * dy);
        // far branch cannot be hit with 13-bit coordinates but is kept anyway
        if (sum >= FAR_SUM) begin
            ramp = ONE_Q16;
        end else begin
            // distance sqrt(sum)/h in q.16, rounded: the largest q whose
            // lower rounding edge (q - 0.5) still lies under the true value
            distance = 0;
            bound    = 128'(sum) << 34;
            for (int b = 16; b >= 0; b--) begin
                trial = distance | (64'd1 << b);
                span  = 128'(2 * trial - 1) * 128'(h);
                if (span * span <= bound) distance = trial;
            end
            ramp = (distance > RAMP_EDGE) ? distance - RAMP_EDGE : 0;
            if (ramp > ONE_Q16) ramp = ONE_Q16;
        end
        // smoothstep t*t*(3-2t)
        ramp_sq = (ramp * ramp + 32768) >> 16;
        taper   = 3 * ONE_Q16 - 2 * ramp;
        smooth  = (ramp_sq * taper + 32768) >> 16;
        if (smooth > ONE_Q16) smooth = ONE_Q16;
        dark = (smooth * st + 16384) >> 15;
        if (dark > ONE_Q16) dark = ONE_Q16;
        gain = ONE_Q16 - dark;
        shaded.red   = 16'((longint'(px.color.red)   * gain + 32768) >> 16);
        shaded.green = 16'((longint'(px.color.green) * gain + 32768) >> 16);
        shaded.blue  = 16'((longint'(px.color.blue)  * gain + 32768) >> 16);
        return shaded;
    endfunction

    // offer one pixel, with random idle cycles in front, until it is taken
    task automatic send_pixel(input logic [COORD_BITS-1:0] row,
                              input logic [COORD_BITS-1:0] col,
                              input logic [COLOR_BITS-1:0] red,
                              input logic [COLOR_BITS-1:0] green,
                              input logic [COLOR_BITS-1:0] blue);
        pixel_t px;
        px.row         = row;
        px.col         = col;
        px.color.red   = red;
        px.color.green = green;
        px.color.blue  = blue;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_TDATA_W - IN_RAW_BITS){1'b0}}, px.color, px.col, px.row};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        // registers only change while idle, so the shadow is current here
        shaded_due.push_back(shade_pixel(px));
        pixels_sent++;
    endtask

    // stop offering items and wait until every owed result is out
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (shaded_due.size() != 0) @(posedge aclk);
    endtask

    // one register write; called only while the block is idle
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            CFG_IMAGE_WIDTH:       img_width  = value[DIM_BITS-1:0];
            CFG_IMAGE_HEIGHT:      img_height = value[DIM_BITS-1:0];
            CFG_VIGNETTE_STRENGTH: strength   = value;
            default: ;
        endcase
        regs_written++;
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // reset values: 1024 x 768 frame at half strength
    task automatic test_reset_defaults();
        // frame center, no darkening
        send_pixel(13'd384, 13'd512, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_pixel(13'd0, 13'd0, 16'h0000, 16'h0000, 16'h0000);
        send_pixel(13'd8191, 13'd8191, 16'hFFFF, 16'hAAAA, 16'h5555);
        send_pixel(13'd767, 13'd1023, 16'h5555, 16'hAAAA, 16'hFFFF);
        send_pixel(13'd384, 13'd0, 16'h8000, 16'h0001, 16'hFFFE);
        wait_idle();
    endtask

    // smallest and largest legal frames, no and full strength
    task automatic test_geometry_extremes();
        write_reg(CFG_IMAGE_WIDTH, 16'd1);
        write_reg(CFG_IMAGE_HEIGHT, 16'd1);
        write_reg(CFG_VIGNETTE_STRENGTH, 16'd0);
        send_pixel(13'd0, 13'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_pixel(13'd8191, 13'd8191, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        wait_idle();
        write_reg(CFG_IMAGE_WIDTH, 16'd8192);
        write_reg(CFG_IMAGE_HEIGHT, 16'd8192);
        write_reg(CFG_VIGNETTE_STRENGTH, 16'd32768);
        send_pixel(13'd4096, 13'd4096, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_pixel(13'd0, 13'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_pixel(13'd8191, 13'd0, 16'hAAAA, 16'hAAAA, 16'hAAAA);
        send_pixel(13'd0, 13'd8191, 16'h5555, 16'h5555, 16'h5555);
        send_pixel(13'd8191, 13'd8191, 16'hFFFF, 16'h0000, 16'hFFFF);
        wait_idle();
    endtask

    // zero width kept as is, zero height taken as one, strength saturating
    task automatic test_zero_dims();
        write_reg(CFG_IMAGE_WIDTH, 16'd0);
        write_reg(CFG_IMAGE_HEIGHT, 16'd0);
        write_reg(CFG_VIGNETTE_STRENGTH, 16'hFFFF);
        send_pixel(13'd0, 13'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_pixel(13'd0, 13'd1, 16'hFFFF, 16'h8000, 16'h0001);
        send_pixel(13'd8191, 13'd8191, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        wait_idle();
    endtask

    // register data above 14 bits is dropped, unused index is ignored
    task automatic test_wide_and_unused();
        write_reg(CFG_IMAGE_WIDTH, 16'hFFFF);
        write_reg(CFG_IMAGE_HEIGHT, 16'h4001);
        write_reg(CFG_VIGNETTE_STRENGTH, 16'd32769);
        write_reg(CFG_UNUSED_INDEX, 16'hFFFF);
        // largest distance sum the coordinates can reach
        send_pixel(13'd8191, 13'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_pixel(13'd0, 13'd8191, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        wait_idle();
        write_reg(CFG_IMAGE_WIDTH, 16'hC280);
        write_reg(CFG_IMAGE_HEIGHT, 16'h81E0);
        write_reg(CFG_UNUSED_INDEX, 16'h0000);
        send_pixel(13'd240, 13'd320, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_pixel(13'd479, 13'd639, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        wait_idle();
    endtask

    function automatic logic [CFG_DATA_BITS-1:0] random_dim();
        case ($urandom_range(0, 9))
            0:       return 16'd1;
            1:       return 16'd8192;
            2:       return 16'($urandom);
            default: return 16'($urandom_range(16, 8192));
        endcase
    endfunction

    function automatic logic [COLOR_BITS-1:0] random_color();
        case ($urandom_range(0, 19))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // new random frame setup, then a burst of pixels mostly inside the frame
    task automatic run_random_block(input int count);
        int row_span;
        int col_span;
        logic [COORD_BITS-1:0] row;
        logic [COORD_BITS-1:0] col;
        write_reg(CFG_IMAGE_WIDTH, random_dim());
        write_reg(CFG_IMAGE_HEIGHT, random_dim());
        case ($urandom_range(0, 7))
            0:       write_reg(CFG_VIGNETTE_STRENGTH, 16'd0);
            1:       write_reg(CFG_VIGNETTE_STRENGTH, STRENGTH_MAX);
            2:       write_reg(CFG_VIGNETTE_STRENGTH, 16'($urandom_range(32769, 65535)));
            default: write_reg(CFG_VIGNETTE_STRENGTH, 16'($urandom_range(0, 32768)));
        endcase
        if ($urandom_range(0, 3) == 0) write_reg(CFG_UNUSED_INDEX, 16'($urandom));
        row_span = (img_height == 0) ? 1 : img_height;
        col_span = (img_width == 0) ? 1 : img_width;
        if (row_span > 8192) row_span = 8192;
        if (col_span > 8192) col_span = 8192;
        repeat (count) begin
            if ($urandom_range(0, 99) < 80) begin
                row = 13'($urandom_range(0, row_span - 1));
                col = 13'($urandom_range(0, col_span - 1));
            end else begin
                row = 13'($urandom);
                col = 13'($urandom);
            end
            send_pixel(row, col, random_color(), random_color(), random_color());
        end
        wait_idle();
    endtask

    // three idle mixes, each over several random frame setups
    task automatic test_random_traffic();
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 15;
                    recv_idle_pct = 53;
                end
                1: begin
                    send_idle_pct = 53;
                    recv_idle_pct = 15;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            repeat (4) run_random_block(92);
        end
    endtask

    // result side backpressure
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // every result against the oldest owed shading
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            result_seen = m_tdata[OUT_RAW_BITS-1:0];
            if (shaded_due.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h", result_seen));
            end else begin
                result_owed = shaded_due.pop_front();
                if (result_seen.red !== result_owed.red)
                    report_mismatch($sformatf("red_out %h, expected %h",
                                              result_seen.red, result_owed.red));
                if (result_seen.green !== result_owed.green)
                    report_mismatch($sformatf("green_out %h, expected %h",
                                              result_seen.green, result_owed.green));
                if (result_seen.blue !== result_owed.blue)
                    report_mismatch($sformatf("blue_out %h, expected %h",
                                              result_seen.blue, result_owed.blue));
                pixels_checked++;
            end
        end
    end

    // watchdog on lack of progress
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
            $display("[radial_vignette_shading] ERROR");
            $finish;
        end
    end

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_defaults();
        test_geometry_extremes();
        test_zero_dims();
        test_wide_and_unused();
        test_random_traffic();
        wait_idle();
        // nothing may come out after the last owed result
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (shaded_due.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", shaded_due.size()));
        $display("covered %0d pixels over %0d register writes, all three idle mixes",
                 pixels_sent, regs_written);
        $display("checked %0d results, %0d mismatches", pixels_checked, errors);
        if (errors == 0) begin
            $display("[radial_vignette_shading] OK");
        end else begin
            $display("[radial_vignette_shading] ERROR");
        end
        $finish;
    end

endmodule
